### design/wgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg
// Types and constants shared by the wildcard glob matcher modules.
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam logic [7:0] SYM_STAR     = 8'd42;
	localparam logic [7:0] SYM_QUESTION = 8'd63;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TEXT   = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  symbol;
	} item_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} result_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_APPEND,
		OP_TEXT,
		OP_FINISH,
		OP_CLOSE
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic [7:0]  symbol;
	} dp_cmd_t;

endpackage

### design/wgm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_ctrl
// Controller: takes one item, issues its datapath operation, then a star
// closure pass; owns the result valid flag.
// ----------------------------------------------------------------------------
module wgm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wgm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wgm_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_CLOSE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take;

	assign item_stall = (state_q != ST_IDLE)
		|| ((item.kind == wgm_pkg::KIND_END) && out_valid_q && result_stall);
	assign take         = item_valid && !item_stall;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.symbol = item.symbol;
		cmd.op     = wgm_pkg::OP_NONE;
		if (state_q == ST_CLOSE) begin
			cmd.op = wgm_pkg::OP_CLOSE;
		end else if (take) begin
			unique case (item.kind)
				wgm_pkg::KIND_CLEAR:  cmd.op = wgm_pkg::OP_CLEAR;
				wgm_pkg::KIND_APPEND: cmd.op = wgm_pkg::OP_APPEND;
				wgm_pkg::KIND_TEXT:   cmd.op = wgm_pkg::OP_TEXT;
				wgm_pkg::KIND_END:    cmd.op = wgm_pkg::OP_FINISH;
				default:              cmd.op = wgm_pkg::OP_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take && (item.kind == wgm_pkg::KIND_END)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/wgm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_dp
// Datapath: pattern cells, active position vector, star closure scan and
// the result register.
// ----------------------------------------------------------------------------
module wgm_dp #(
	parameter int MAX_PATTERN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wgm_pkg::dp_cmd_t cmd,
	output wgm_pkg::result_t result
);

	localparam int N      = MAX_PATTERN + 1;
	localparam int LW     = $clog2(MAX_PATTERN + 1);
	localparam int IW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEVELS = $clog2(N);

	logic [7:0]             sym_q [MAX_PATTERN];
	logic [LW-1:0]          len_q;
	logic                   ovf_q;
	logic [N-1:0]           act_q;
	wgm_pkg::result_t       res_q;

	logic [MAX_PATTERN-1:0] live;
	logic [MAX_PATTERN-1:0] star;
	logic [MAX_PATTERN-1:0] stay;
	logic [MAX_PATTERN-1:0] adv;
	logic [N-1:0]           step_vec;
	logic [N-1:0]           g_l [0:LEVELS];
	logic [N-1:0]           p_l [0:LEVELS];
	logic [N-1:0]           closed;
	logic                   full;

	assign full = (len_q == LW'(MAX_PATTERN));

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign live[i] = (LW'(i) < len_q);
		assign star[i] = live[i] && (sym_q[i] == wgm_pkg::SYM_STAR);
		assign stay[i] = act_q[i] && star[i];
		assign adv[i]  = act_q[i] && live[i] && !star[i]
			&& ((sym_q[i] == wgm_pkg::SYM_QUESTION) || (sym_q[i] == cmd.symbol));
	end

	assign step_vec = {adv, 1'b0} | {1'b0, stay};

	// segmented prefix scan: bit j inherits from j-1 across a star
	always_comb begin
		g_l[0] = act_q;
		p_l[0] = {star, 1'b0};
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j < N; j++) begin
				if (j >= (1 << l)) begin
					g_l[l+1][j] = g_l[l][j] | (p_l[l][j] & g_l[l][j - (1 << l)]);
					p_l[l+1][j] = p_l[l][j] & p_l[l][j - (1 << l)];
				end else begin
					g_l[l+1][j] = g_l[l][j];
					p_l[l+1][j] = p_l[l][j];
				end
			end
		end
		closed = g_l[LEVELS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			act_q <= N'(1);
		end else begin
			unique case (cmd.op)
				wgm_pkg::OP_CLEAR: begin
					len_q <= '0;
					ovf_q <= 1'b0;
					act_q <= N'(1);
				end
				wgm_pkg::OP_APPEND: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + LW'(1);
					end
					act_q <= N'(1);
				end
				wgm_pkg::OP_TEXT:   act_q <= step_vec;
				wgm_pkg::OP_FINISH: act_q <= N'(1);
				wgm_pkg::OP_CLOSE:  act_q <= closed;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.op == wgm_pkg::OP_APPEND) && !full) begin
			sym_q[len_q[IW-1:0]] <= cmd.symbol;
		end
		if (cmd.op == wgm_pkg::OP_FINISH) begin
			res_q.matched  <= !ovf_q && act_q[len_q];
			res_q.overflow <= ovf_q;
		end
	end

	assign result = res_q;

endmodule

### design/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Whole-string glob matcher ('*' any run, '?' one byte) over a streamed text.
// ----------------------------------------------------------------------------
// Every item (pattern clear, pattern append, text byte, end of text) runs
// an operation on the active-position vector and then the star closure, a
// segmented prefix scan over MAX_PATTERN+1 positions, before the next item.
// End of text loads the result register, which holds the result until it is
// transferred; a later item can be taken meanwhile, except another end of
// text while the result is still stalled.
module wildcard_glob_matcher #(
	parameter int MAX_PATTERN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wgm_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wgm_pkg::result_t result
);

	wgm_pkg::dp_cmd_t cmd;

	wgm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	wgm_dp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result)
	);

endmodule

### verif/glob_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_match_checker
// Predicts and checks the results of the wildcard glob matcher.
// ----------------------------------------------------------------------------
// Watches the item and result channels of the matcher. Every item transfer
// updates a private copy of the pattern store and the active-position set.
// An end of text queues the expected verdict. Every result transfer is
// compared, field by field, against the oldest queued verdict.
module glob_match_checker #(
	parameter int MAX_PATTERN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  wgm_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  wgm_pkg::result_t result,
	output int               errors,
	output int               pending,
	output int               checked,
	output int               hits
);

	logic [7:0]           pat_store [MAX_PATTERN];
	int unsigned          pat_len;
	logic                 pat_overflow;
	logic [MAX_PATTERN:0] live;
	wgm_pkg::result_t     verdict_q [$];
	wgm_pkg::result_t     want;

	function automatic void close_over_stars();
		for (int i = 0; i < MAX_PATTERN; i++)
			if (i < pat_len && live[i] && pat_store[i] == wgm_pkg::SYM_STAR)
				live[i + 1] = 1'b1;
	endfunction

	function automatic void restart_text();
		live = '0;
		live[0] = 1'b1;
		close_over_stars();
	endfunction

	function automatic void advance_text(input logic [7:0] c);
		logic [MAX_PATTERN:0] nxt;
		nxt = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < pat_len && live[i]) begin
				if (pat_store[i] == wgm_pkg::SYM_STAR)
					nxt[i] = 1'b1;
				else if (pat_store[i] == wgm_pkg::SYM_QUESTION || pat_store[i] == c)
					nxt[i + 1] = 1'b1;
			end
		end
		live = nxt;
		close_over_stars();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len = 0;
			pat_overflow = 1'b0;
			restart_text();
			verdict_q.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			hits = 0;
		end else begin
			if (result_valid && !result_stall) begin
				checked++;
				if (verdict_q.size() == 0) begin
					$error("result transfer with no result expected");
					errors++;
				end else begin
					want = verdict_q.pop_front();
					if (want.matched)
						hits++;
					if (result.matched !== want.matched) begin
						$error("matched: expected %0b, actual %0b", want.matched, result.matched);
						errors++;
					end
					if (result.overflow !== want.overflow) begin
						$error("overflow: expected %0b, actual %0b", want.overflow,
							result.overflow);
						errors++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				case (item.kind)
					wgm_pkg::KIND_CLEAR: begin
						pat_len = 0;
						pat_overflow = 1'b0;
						restart_text();
					end
					wgm_pkg::KIND_APPEND: begin
						if (pat_len < MAX_PATTERN) begin
							pat_store[pat_len] = item.symbol;
							pat_len++;
						end else begin
							pat_overflow = 1'b1;
						end
						restart_text();
					end
					wgm_pkg::KIND_TEXT: begin
						advance_text(item.symbol);
					end
					default: begin
						want.matched = !pat_overflow && live[pat_len];
						want.overflow = pat_overflow;
						verdict_q.push_back(want);
						restart_text();
					end
				endcase
			end
			pending = verdict_q.size();
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the wildcard glob matcher.
// ----------------------------------------------------------------------------
// A short directed run covers empty patterns and texts, all-star patterns,
// '?', extreme byte values and a pattern change in the middle of a text.
// Random runs then load patterns (a few longer than the store) and stream
// texts built to fit them, some of them mangled, with stray items mixed in.
// Sender gaps and receiver stalls vary by phase; the checker does the rest.
module testbench;

	localparam int MAX_PATTERN = 64;
	localparam int ITEMS       = 1850;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN       = 20;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_stall;
	wgm_pkg::item_t   item;
	logic             result_valid;
	logic             result_stall;
	wgm_pkg::result_t result;

	int errors, pending, checked, hits;
	int n_sent;
	int phase;
	int cycles = 0;
	logic [7:0] pat_q [$];

	wildcard_glob_matcher #(.MAX_PATTERN(MAX_PATTERN)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	glob_match_checker #(.MAX_PATTERN(MAX_PATTERN)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked),
		.hits        (hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < ((phase == 0) ? 49 : (phase == 1) ? 32 : 0));
	end

	task automatic send(input wgm_pkg::kind_t k, input logic [7:0] s);
		int idle_pct;
		idle_pct = (phase == 0) ? 32 : (phase == 1) ? 49 : 0;
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{kind: k, symbol: s};
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		n_sent++;
		phase <= (n_sent * 3 / ITEMS > 2) ? 2 : n_sent * 3 / ITEMS;
	endtask

	function automatic logic [7:0] pattern_sym();
		case ($urandom_range(9))
			0, 1, 2: return "a";
			3, 4:    return "b";
			5, 6:    return wgm_pkg::SYM_STAR;
			7:       return wgm_pkg::SYM_QUESTION;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] text_sym();
		case ($urandom_range(7))
			0, 1, 2, 3: return "a";
			4, 5:       return "b";
			6:          return "c";
			default:    return 8'($urandom_range(255));
		endcase
	endfunction

	// text shaped after pat_q, mangled now and then
	task automatic send_text();
		logic [7:0] txt [$];
		int at;
		txt = {};
		foreach (pat_q[i]) begin
			if (pat_q[i] == wgm_pkg::SYM_STAR)
				repeat ($urandom_range(2)) txt.push_back(text_sym());
			else if (pat_q[i] == wgm_pkg::SYM_QUESTION)
				txt.push_back(8'($urandom_range(255)));
			else
				txt.push_back(pat_q[i]);
		end
		if ($urandom_range(3) == 0) begin
			at = $urandom_range(txt.size());
			case ($urandom_range(2))
				0:       txt.insert(at, text_sym());
				1:       if (at < txt.size()) txt.delete(at);
				default: if (at < txt.size()) txt[at] = text_sym();
			endcase
		end
		foreach (txt[i])
			send(wgm_pkg::KIND_TEXT, txt[i]);
		send(wgm_pkg::KIND_END, 8'($urandom_range(255)));
	endtask

	initial begin
		int len;
		item_valid <= 1'b0;
		item <= '0;
		phase <= 0;
		n_sent = 0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern: empty text matches, one byte does not
		send(wgm_pkg::KIND_END, 8'h00);
		send(wgm_pkg::KIND_TEXT, "a");
		send(wgm_pkg::KIND_END, 8'hFF);
		// all stars
		send(wgm_pkg::KIND_APPEND, wgm_pkg::SYM_STAR);
		send(wgm_pkg::KIND_APPEND, wgm_pkg::SYM_STAR);
		send(wgm_pkg::KIND_END, 8'h00);
		send(wgm_pkg::KIND_TEXT, 8'h00);
		send(wgm_pkg::KIND_TEXT, 8'hFF);
		send(wgm_pkg::KIND_END, 8'h00);
		// a?*c
		send(wgm_pkg::KIND_CLEAR, 8'hFF);
		send(wgm_pkg::KIND_APPEND, "a");
		send(wgm_pkg::KIND_APPEND, wgm_pkg::SYM_QUESTION);
		send(wgm_pkg::KIND_APPEND, wgm_pkg::SYM_STAR);
		send(wgm_pkg::KIND_APPEND, "c");
		send(wgm_pkg::KIND_TEXT, "a");
		send(wgm_pkg::KIND_TEXT, 8'hFF);
		send(wgm_pkg::KIND_TEXT, "c");
		send(wgm_pkg::KIND_END, 8'h00);
		send(wgm_pkg::KIND_TEXT, "a");
		send(wgm_pkg::KIND_END, 8'h00);
		// append mid-text drops the bytes already streamed
		send(wgm_pkg::KIND_TEXT, "a");
		send(wgm_pkg::KIND_APPEND, 8'h00);
		send(wgm_pkg::KIND_TEXT, "a");
		send(wgm_pkg::KIND_TEXT, "b");
		send(wgm_pkg::KIND_TEXT, "c");
		send(wgm_pkg::KIND_TEXT, 8'h00);
		send(wgm_pkg::KIND_END, 8'h00);

		while (n_sent < ITEMS) begin
			send(wgm_pkg::KIND_CLEAR, 8'($urandom_range(255)));
			pat_q = {};
			len = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(8);
			repeat (len) pat_q.push_back(pattern_sym());
			foreach (pat_q[i])
				send(wgm_pkg::KIND_APPEND, pat_q[i]);
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(9) == 0)
					send(wgm_pkg::kind_t'($urandom_range(3)), 8'($urandom_range(255)));
				send_text();
			end
		end
		item_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d items; checked %0d end-of-text results, %0d of them matches.",
			n_sent, checked, hits);
		$display("Patterns up to 70 symbols on a %0d-entry store, under three idle mixes.",
			MAX_PATTERN);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
